>>> design/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared sizes, the controller command bundle and the state type.
// ----------------------------------------------------------------------------
package lrupr_pkg;

  // Number of page slots in the store.
  localparam int CAPACITY = 64;

  // Field widths fixed by the interface.
  localparam int PAGE_W = 16;
  localparam int WAYS_W = 7;
  localparam int HITS_W = 32;

  // Occupancy counter holds 0 .. CAPACITY.
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // Slot index width.
  localparam int IDX_W = $clog2(CAPACITY);
  // Common width for comparing the way limit against occupancy.
  localparam int EXT_W = (CNT_W > WAYS_W) ? CNT_W : WAYS_W;
  // Levels of the parallel prefix OR over the match vector.
  localparam int PFX_LVLS = IDX_W;

  // Controller states.
  typedef enum logic [0:0] {
    S_IDLE,
    S_UPDATE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // Register the page and its match vector.
    logic update;   // Apply the reorder and load the result register.
  } cmd_t;

endpackage

>>> design/lrupr_ctrl.sv
// ----------------------------------------------------------------------------
// LRU page replacement controller
// Sequences one reference through capture and update, and owns the
// handshake state of both channels.
// ----------------------------------------------------------------------------
module lrupr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lrupr_pkg::cmd_t cmd_o
);
  import lrupr_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // The result register can take a new beat when empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (out_free) begin
          cmd_o.update = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and result-valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> design/lrupr_dpath.sv
// ----------------------------------------------------------------------------
// LRU page replacement datapath
// Recency list as a row of slot registers with parallel compare, a prefix
// mask that selects which slots shift down, occupancy and hit counters, the
// way-limit register and the result register.
// ----------------------------------------------------------------------------
module lrupr_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lrupr_pkg::cmd_t               cmd_i,
  input  logic                          cfg_we_i,
  input  logic [lrupr_pkg::WAYS_W-1:0]  cfg_wdata_i,
  input  logic [lrupr_pkg::PAGE_W-1:0]  in_page_i,
  output logic                          out_hit_o,
  output logic                          out_evicted_valid_o,
  output logic [lrupr_pkg::PAGE_W-1:0]  out_evicted_page_o,
  output logic [lrupr_pkg::HITS_W-1:0]  out_hits_so_far_o
);
  import lrupr_pkg::*;

  logic [PAGE_W-1:0]   list_q [CAPACITY];
  logic [CAPACITY-1:0] match_q;
  logic [PAGE_W-1:0]   page_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [HITS_W-1:0]   hits_q, hits_d;
  logic [WAYS_W-1:0]   ways_q;

  logic                hit_q;
  logic                ev_valid_q;
  logic [PAGE_W-1:0]   ev_page_q;

  logic [CAPACITY-1:0] match_d;
  logic [EXT_W-1:0]    limit;
  logic                enabled;
  logic                hit;
  logic                evict;
  logic [CNT_W-1:0]    wr_pos;
  logic [CAPACITY-1:0] pfx [PFX_LVLS+1];
  logic [CAPACITY-1:0] shift_en;
  logic [CAPACITY-1:0] wr_en;

  // Way-limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ways_q <= WAYS_W'(CAPACITY > 64 ? 64 : CAPACITY) | WAYS_W'(64);
    end else if (cfg_we_i) begin
      ways_q <= cfg_wdata_i;
    end
  end

  // Compare the incoming page against every occupied slot.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_d[i] = (list_q[i] == in_page_i) && (CNT_W'(i) < count_q);
    end
  end

  // Effective limit is the smaller of the register and the capacity.
  always_comb begin
    if (EXT_W'(ways_q) > EXT_W'(CAPACITY)) begin
      limit = EXT_W'(CAPACITY);
    end else begin
      limit = EXT_W'(ways_q);
    end
  end

  assign enabled = (limit != '0);
  assign hit     = enabled && (|match_q);
  assign evict   = enabled && !(|match_q) && (EXT_W'(count_q) >= limit);

  // Prefix OR: a slot at or above the hit position is marked.
  always_comb begin
    pfx[0] = match_q;
    for (int l = 0; l < PFX_LVLS; l++) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (i >= (1 << l)) begin
          pfx[l+1][i] = pfx[l][i] | pfx[l][i - (1 << l)];
        end else begin
          pfx[l+1][i] = pfx[l][i];
        end
      end
    end
  end

  // A hit closes the gap above the hit slot; an eviction shifts everything.
  // The new most recent page lands in the last occupied slot, or the first
  // free slot when filling.
  always_comb begin
    if (hit || evict) begin
      wr_pos = count_q - CNT_W'(1);
    end else begin
      wr_pos = count_q;
    end
    for (int i = 0; i < CAPACITY; i++) begin
      shift_en[i] = (hit ? pfx[PFX_LVLS][i] : evict) && (CNT_W'(i + 1) < count_q);
      wr_en[i]    = enabled && (CNT_W'(i) == wr_pos);
    end
  end

  // Occupancy and hit counters.
  always_comb begin
    count_d = count_q;
    if (enabled && !hit && !evict) begin
      count_d = count_q + CNT_W'(1);
    end
    hits_d = hits_q;
    if (hit && (hits_q != '1)) begin
      hits_d = hits_q + HITS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      hits_q  <= '0;
    end else if (cmd_i.update) begin
      count_q <= count_d;
      hits_q  <= hits_d;
    end
  end

  // Captured reference and its match vector.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      page_q  <= in_page_i;
      match_q <= match_d;
    end
  end

  // Slot registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (wr_en[i]) begin
          list_q[i] <= page_q;
        end else if (shift_en[i] && (i < CAPACITY - 1)) begin
          list_q[i] <= list_q[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      hit_q      <= hit;
      ev_valid_q <= evict;
      ev_page_q  <= evict ? list_q[0] : '0;
    end
  end

  assign out_hit_o           = hit_q;
  assign out_evicted_valid_o = ev_valid_q;
  assign out_evicted_page_o  = ev_page_q;
  assign out_hits_so_far_o   = hits_q;

endmodule

>>> design/lru_page_replacement_top.sv
// ----------------------------------------------------------------------------
// LRU page replacement top level
// Fully associative page store ordered from least to most recently used.
//
//   Channel  Direction  Handshake                 Payload
//   cfg      in         cfg_we_i                  cfg_wdata_i (ways in use)
//   in       in         in_valid_i / in_stall_o   in_page_i
//   out      out        out_valid_o / out_stall_i out_hit_o, out_evicted_valid_o,
//                                                 out_evicted_page_o,
//                                                 out_hits_so_far_o
//
// Each reference is captured, comparing the page against all slots in
// parallel; the update then reorders the slot row and loads the result register.
// The input stalls while a reference is in flight and while the update
// waits for the result register to drain.
// Reset empties the store, clears the hit count and sets ways in use to 64.
// ----------------------------------------------------------------------------
module lru_page_replacement_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lrupr_pkg::WAYS_W-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lrupr_pkg::PAGE_W-1:0]  in_page_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          out_hit_o,
  output logic                          out_evicted_valid_o,
  output logic [lrupr_pkg::PAGE_W-1:0]  out_evicted_page_o,
  output logic [lrupr_pkg::HITS_W-1:0]  out_hits_so_far_o
);
  import lrupr_pkg::*;

  cmd_t cmd;

  // Sequencing and handshakes.
  lrupr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Slot row, counters and result register.
  lrupr_dpath u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_page_i           (in_page_i),
    .out_hit_o           (out_hit_o),
    .out_evicted_valid_o (out_evicted_valid_o),
    .out_evicted_page_o  (out_evicted_page_o),
    .out_hits_so_far_o   (out_hits_so_far_o)
  );

endmodule
